// ===== rtl/core/lr_pkg.sv =====
// ----------------------------------------------------------------------------
// lr_pkg
// Request codes and widths shared by the line rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lr_pkg;

  // Request type carried on each input beat.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  // Extra bits that the decision term carries beyond the coordinate width.
  localparam int unsigned DECISION_EXTRA = 4;

  typedef logic req_t;

endpackage

// ===== rtl/core/line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// line_rasterizer
// Integer midpoint line rasterizer for all octants, at most one pixel per beat.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | in_valid / in_ready | req_type, x_start, y_start,
//          |           |                     | x_end, y_end
//  out     | output    | out_valid/out_ready | pixel_x, pixel_y, last_pixel
//
// Each input beat is handled in the cycle it is accepted: the setup or one
// step of the midpoint loop sits between the line state and the result
// register, and the pixel appears in the next cycle. The result register alone
// parts the two sides; the input takes a new beat, one per cycle, whenever
// that register is empty or is being drained in the same cycle.
// A next request with no active line is accepted and yields no pixel.
// Reset (synchronous, active high) clears the line state and the result valid.
`timescale 1ns / 1ps

module line_rasterizer #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lr_pkg::req_t                 req_type,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         last_pixel
);

  import lr_pkg::*;

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = COORD_BITS + DECISION_EXTRA;

  // Line state.
  logic signed [CW-1:0] current_x, current_y, target_x, target_y;
  logic        [CW:0]   delta_x, delta_y;
  logic signed [DW-1:0] decision;
  logic                 step_x_negative, step_y_negative, x_is_major, line_active;

  logic signed [CW-1:0] current_x_next, current_y_next, target_x_next, target_y_next;
  logic        [CW:0]   delta_x_next, delta_y_next;
  logic signed [DW-1:0] decision_next;
  logic                 step_x_negative_next, step_y_negative_next;
  logic                 x_is_major_next, line_active_next;

  logic                 in_beat, produce, last_next, out_valid_next;

  // Setup terms.
  logic signed [CW:0]   xs_ext, ys_ext, xe_ext, ye_ext;
  logic                 sxn_new, syn_new;
  logic        [CW:0]   dx_new, dy_new;
  logic signed [DW-1:0] dx_new_ext, dy_new_ext;

  // Step terms.
  logic signed [DW-1:0] dx_ext, dy_ext;
  logic signed [CW-1:0] x_stepped, y_stepped;

  assign in_ready = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;

  always_comb begin
    xs_ext     = {x_start[CW-1], x_start};
    ys_ext     = {y_start[CW-1], y_start};
    xe_ext     = {x_end[CW-1], x_end};
    ye_ext     = {y_end[CW-1], y_end};
    sxn_new    = x_end < x_start;
    syn_new    = y_end < y_start;
    dx_new     = sxn_new ? (CW+1)'(xs_ext - xe_ext) : (CW+1)'(xe_ext - xs_ext);
    dy_new     = syn_new ? (CW+1)'(ys_ext - ye_ext) : (CW+1)'(ye_ext - ys_ext);
    dx_new_ext = signed'({{(DW-CW-1){1'b0}}, dx_new});
    dy_new_ext = signed'({{(DW-CW-1){1'b0}}, dy_new});

    dx_ext    = signed'({{(DW-CW-1){1'b0}}, delta_x});
    dy_ext    = signed'({{(DW-CW-1){1'b0}}, delta_y});
    x_stepped = step_x_negative ? current_x - CW'(1) : current_x + CW'(1);
    y_stepped = step_y_negative ? current_y - CW'(1) : current_y + CW'(1);
  end

  always_comb begin
    current_x_next       = current_x;
    current_y_next       = current_y;
    target_x_next        = target_x;
    target_y_next        = target_y;
    delta_x_next         = delta_x;
    delta_y_next         = delta_y;
    decision_next        = decision;
    step_x_negative_next = step_x_negative;
    step_y_negative_next = step_y_negative;
    x_is_major_next      = x_is_major;
    line_active_next     = line_active;
    produce              = 1'b0;
    last_next            = 1'b0;

    if (in_beat) begin
      if (req_type == REQ_START) begin
        current_x_next       = x_start;
        current_y_next       = y_start;
        target_x_next        = x_end;
        target_y_next        = y_end;
        step_x_negative_next = sxn_new;
        step_y_negative_next = syn_new;
        delta_x_next         = dx_new;
        delta_y_next         = dy_new;
        x_is_major_next      = dx_new >= dy_new;
        decision_next        = (dx_new >= dy_new) ? (dy_new_ext <<< 1) - dx_new_ext
                                                  : (dx_new_ext <<< 1) - dy_new_ext;
        line_active_next     = (dx_new != '0) || (dy_new != '0);
        produce              = 1'b1;
        last_next            = (dx_new == '0) && (dy_new == '0);
      end else if (line_active) begin
        produce = 1'b1;
        if (x_is_major) begin
          if (decision < 0) begin
            decision_next = decision + (dy_ext <<< 1);
          end else begin
            decision_next  = decision + ((dy_ext - dx_ext) <<< 1);
            current_y_next = y_stepped;
          end
          current_x_next = x_stepped;
          last_next      = x_stepped == target_x;
        end else begin
          if (decision < 0) begin
            decision_next = decision + (dx_ext <<< 1);
          end else begin
            decision_next  = decision + ((dx_ext - dy_ext) <<< 1);
            current_x_next = x_stepped;
          end
          current_y_next = y_stepped;
          last_next      = y_stepped == target_y;
        end
        if (last_next) begin
          line_active_next = 1'b0;
        end
      end
    end

    if (produce) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_x       <= '0;
      current_y       <= '0;
      target_x        <= '0;
      target_y        <= '0;
      delta_x         <= '0;
      delta_y         <= '0;
      decision        <= '0;
      step_x_negative <= 1'b0;
      step_y_negative <= 1'b0;
      x_is_major      <= 1'b0;
      line_active     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      current_x       <= current_x_next;
      current_y       <= current_y_next;
      target_x        <= target_x_next;
      target_y        <= target_y_next;
      delta_x         <= delta_x_next;
      delta_y         <= delta_y_next;
      decision        <= decision_next;
      step_x_negative <= step_x_negative_next;
      step_y_negative <= step_y_negative_next;
      x_is_major      <= x_is_major_next;
      line_active     <= line_active_next;
      out_valid       <= out_valid_next;
    end
  end

  // The pixel register loads only when a new pixel is produced.
  always_ff @(posedge clk) begin
    if (produce) begin
      pixel_x    <= current_x_next;
      pixel_y    <= current_y_next;
      last_pixel <= last_next;
    end
  end

endmodule
